// File: src/telnet_line_assembler_top_assert.svh
// assertion macros for the telnet line assembler checker
`ifndef TELNET_LINE_ASSEMBLER_TOP_ASSERT_SVH
`define TELNET_LINE_ASSEMBLER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define TLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tla_pkg.sv
// shared types and constants for the telnet line assembler
`default_nettype none

package tla_pkg;

  localparam int unsigned LINE_CAPACITY_DEFAULT = 64;
  localparam int unsigned TOK_FIFO_DEPTH        = 4;

  localparam logic [7:0] BYTE_CMD      = 8'd255;
  localparam logic [7:0] OPT_THRESHOLD = 8'd250;
  localparam logic [7:0] PRINT_LOW     = 8'd32;
  localparam logic [7:0] PRINT_END     = 8'd127;
  localparam logic [7:0] BYTE_NL       = 8'd10;
  localparam logic [6:0] CHAR_SPACE    = 7'd32;

  typedef enum logic [1:0] {
    STAT_CHAR     = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERLONG = 2'd2
  } tla_status_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CMD  = 3'b010,
    PH_OPT  = 3'b100
  } tla_phase_e;

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_FETCH   = 3'b010,
    ST_EMIT    = 3'b100
  } tla_state_e;

  typedef struct packed {
    logic       nl;
    logic [6:0] ch;
  } tla_tok_t;

endpackage

`default_nettype wire

// File: src/tla_if.sv
// channel interfaces for received bytes and line results
`default_nettype none

interface tla_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
  modport monitor (input valid, input rx_byte, input ready);
endinterface

interface tla_line_if;
  logic       valid;
  logic       ready;
  logic [6:0] line_char;
  logic [1:0] line_status;
  logic       end_of_line;

  modport source (output valid, output line_char, output line_status, output end_of_line,
                  input ready);
  modport sink (input valid, input line_char, input line_status, input end_of_line,
                output ready);
  modport monitor (input valid, input line_char, input line_status, input end_of_line,
                   input ready);
endinterface

`default_nettype wire

// File: src/telnet_line_assembler_top.sv
// top level of the telnet line assembler
// rx: one raw byte per transaction, valid/ready; telnet command sequences
//   (255, the next byte, and one more when that byte is 250 or above) are dropped
// line: one transaction per result; line_status 0 carries a trimmed character,
//   1 an empty or all-space line, 2 an overlong line; end_of_line marks the last
// throughput: one byte per cycle while a line is collected and no newline waits
//   on a stalled line receiver; the front end takes a byte every cycle as long
//   as the four-entry token queue has room
// a status result goes into the output register as its newline leaves the queue;
//   a trimmed line is read out one character at a time, each by a registered
//   read of the line store followed by the output register load
// during readout the back end takes no tokens, so the queue fills and rx.ready
//   drops after four more printable or newline bytes
// when the line receiver stalls, the output register holds its transaction and
//   readout waits; the queue then backs up into rx
// reset clears the command phase, the line length and trim state, the queue and
//   the output valid flag; the line store and the output data are not cleared
// LINE_CAPACITY (2..64) sets the store depth; at most LINE_CAPACITY-1 characters
`default_nettype none

module telnet_line_assembler_top import tla_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tla_rx_if.sink     rx,
  tla_line_if.source line
);

  tla_tok_t push_tok;
  tla_tok_t head_tok;
  logic     tok_push;
  logic     tok_pop;
  logic     fifo_full;
  logic     fifo_valid;

  tla_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx),
    .fifo_full_i (fifo_full),
    .tok_push_o  (tok_push),
    .tok_o       (push_tok)
  );

  tla_tok_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .tok_i   (push_tok),
    .full_o  (fifo_full),
    .pop_i   (tok_pop),
    .tok_o   (head_tok),
    .valid_o (fifo_valid)
  );

  tla_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (head_tok),
    .tok_valid_i (fifo_valid),
    .tok_pop_o   (tok_pop),
    .line        (line)
  );

endmodule

`default_nettype wire

// File: src/tla_front.sv
// front end: telnet command stripping and byte classification
`default_nettype none

module tla_front import tla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tla_rx_if.sink    rx,
  input  logic      fifo_full_i,
  output logic      tok_push_o,
  output tla_tok_t  tok_o
);

  tla_phase_e phase_q, phase_d;
  logic       accept;

  assign rx.ready = !fifo_full_i;
  assign accept   = rx.valid && rx.ready;

  assign tok_o.nl = (rx.rx_byte == BYTE_NL);
  assign tok_o.ch = rx.rx_byte[6:0];

  always_comb begin
    phase_d    = phase_q;
    tok_push_o = 1'b0;
    case (phase_q)
      PH_CMD: begin
        if (accept) begin
          phase_d = (rx.rx_byte >= OPT_THRESHOLD) ? PH_OPT : PH_IDLE;
        end
      end
      PH_OPT: begin
        if (accept) begin
          phase_d = PH_IDLE;
        end
      end
      PH_IDLE: begin
        if (accept) begin
          if (rx.rx_byte == BYTE_CMD) begin
            phase_d = PH_CMD;
          end else if (rx.rx_byte == BYTE_NL) begin
            tok_push_o = 1'b1;
          end else if (rx.rx_byte >= PRINT_LOW && rx.rx_byte < PRINT_END) begin
            tok_push_o = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// File: src/tla_tok_fifo.sv
// short token queue between front and back end
`default_nettype none

module tla_tok_fifo import tla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tla_tok_t tok_i,
  output logic     full_o,
  input  logic     pop_i,
  output tla_tok_t tok_o,
  output logic     valid_o
);

  localparam int unsigned PW = $clog2(TOK_FIFO_DEPTH);

  tla_tok_t      slot_q [TOK_FIFO_DEPTH];
  logic [PW:0]   wr_ptr_q, wr_ptr_d;
  logic [PW:0]   rd_ptr_q, rd_ptr_d;

  assign full_o  = (wr_ptr_q[PW] != rd_ptr_q[PW]) &&
                   (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign tok_o   = slot_q[rd_ptr_q[PW-1:0]];

  assign wr_ptr_d = wr_ptr_q + (PW+1)'(push_i && !full_o);
  assign rd_ptr_d = rd_ptr_q + (PW+1)'(pop_i && valid_o);

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wr_ptr_q[PW-1:0]] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

`default_nettype wire

// File: src/tla_back.sv
// back end: line store, trim tracking and line readout
`default_nettype none

module tla_back import tla_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tla_tok_t   tok_i,
  input  logic       tok_valid_i,
  output logic       tok_pop_o,
  tla_line_if.source line
);

  localparam int unsigned AW = $clog2(LINE_CAPACITY);

  logic [6:0]  store_q [LINE_CAPACITY];
  logic [6:0]  rd_data_q;

  tla_state_e  state_q, state_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] first_q, first_d;
  logic [AW-1:0] last_q, last_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic        overlong_q, overlong_d;
  logic        any_q, any_d;

  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic [6:0]  out_char_q, out_char_d;
  tla_status_e out_status_q, out_status_d;
  logic        out_eol_q, out_eol_d;

  logic        slot_free;
  logic        store_full;
  logic        store_wr;
  logic        line_clear;

  assign slot_free  = !out_valid_q || line.ready;
  assign store_full = (fill_q == AW'(LINE_CAPACITY - 1));
  assign tok_pop_o  = (state_q == ST_COLLECT) && tok_valid_i && (!tok_i.nl || slot_free);
  assign store_wr   = tok_pop_o && !tok_i.nl && !store_full;

  assign line.valid       = out_valid_q;
  assign line.line_char   = out_char_q;
  assign line.line_status = out_status_q;
  assign line.end_of_line = out_eol_q;

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    first_d      = first_q;
    last_d       = last_q;
    ptr_d        = ptr_q;
    overlong_d   = overlong_q;
    any_d        = any_q;
    out_valid_d  = out_valid_q && !line.ready;
    out_load     = 1'b0;
    out_char_d   = out_char_q;
    out_status_d = out_status_q;
    out_eol_d    = out_eol_q;
    line_clear   = 1'b0;
    case (state_q)
      ST_COLLECT: begin
        if (tok_pop_o && !tok_i.nl) begin
          if (store_full) begin
            overlong_d = 1'b1;
          end else begin
            fill_d = fill_q + AW'(1);
            if (tok_i.ch != CHAR_SPACE) begin
              if (!any_q) begin
                first_d = fill_q;
              end
              last_d = fill_q;
              any_d  = 1'b1;
            end
          end
        end else if (tok_pop_o && tok_i.nl) begin
          if (overlong_q) begin
            out_load     = 1'b1;
            out_char_d   = '0;
            out_status_d = STAT_OVERLONG;
            out_eol_d    = 1'b1;
            line_clear   = 1'b1;
          end else if (!any_q) begin
            out_load     = 1'b1;
            out_char_d   = '0;
            out_status_d = STAT_EMPTY;
            out_eol_d    = 1'b1;
            line_clear   = 1'b1;
          end else begin
            ptr_d   = first_q;
            state_d = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_d   = rd_data_q;
          out_status_d = STAT_CHAR;
          out_eol_d    = (ptr_q == last_q);
          if (ptr_q == last_q) begin
            line_clear = 1'b1;
            state_d    = ST_COLLECT;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    if (line_clear) begin
      fill_d     = '0;
      first_d    = '0;
      last_d     = '0;
      overlong_d = 1'b0;
      any_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      store_q[fill_q] <= tok_i.ch;
    end
    if (state_q == ST_FETCH) begin
      rd_data_q <= store_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q   <= out_char_d;
      out_status_q <= out_status_d;
      out_eol_q    <= out_eol_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      fill_q      <= '0;
      first_q     <= '0;
      last_q      <= '0;
      ptr_q       <= '0;
      overlong_q  <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      first_q     <= first_d;
      last_q      <= last_d;
      ptr_q       <= ptr_d;
      overlong_q  <= overlong_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: src/tla_checker.sv
// port-level assertion checker for the telnet line assembler, with its bind
`default_nettype none

`include "telnet_line_assembler_top_assert.svh"

module tla_checker import tla_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       line_valid_i,
  input logic       line_ready_i,
  input logic [6:0] line_char_i,
  input logic [1:0] line_status_i,
  input logic       end_of_line_i
);

  `TLA_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, line_valid_i && !line_ready_i, line_valid_i, "line valid dropped while stalled")

  `TLA_ASSERT_NOW(a_status_legal, clk_i, rst_ni, line_valid_i, line_status_i == STAT_CHAR || line_status_i == STAT_EMPTY || line_status_i == STAT_OVERLONG, "illegal line status")

  `TLA_ASSERT_NOW(a_status_alone, clk_i, rst_ni, line_valid_i && line_status_i != STAT_CHAR, end_of_line_i && line_char_i == 7'd0, "status result not a lone zero end of line")

  `TLA_ASSERT_NOW(a_char_printable, clk_i, rst_ni, line_valid_i && line_status_i == STAT_CHAR, line_char_i >= 7'd32 && line_char_i != 7'd127, "line character not printable")

endmodule

bind telnet_line_assembler_top tla_checker u_tla_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .line_valid_i  (line.valid),
  .line_ready_i  (line.ready),
  .line_char_i   (line.line_char),
  .line_status_i (line.line_status),
  .end_of_line_i (line.end_of_line)
);

`default_nettype wire
